// ===== rtl/mrr_pkg.sv =====
package mrr_pkg;

	// Result codes carried on the verdict port.
	localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
	localparam logic [1:0] VERDICT_PRIME     = 2'd1;
	localparam logic [1:0] VERDICT_INVALID   = 2'd2;

	localparam int unsigned VERDICT_W = 2;
	localparam int unsigned FIELD_W   = 32;
	localparam int unsigned COUNT_W   = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SPLIT,
		ST_SKIP,
		ST_SQR_GO,
		ST_SQR_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_STEP,
		ST_EVAL,
		ST_TEST,
		ST_SQB_GO,
		ST_SQB_WAIT,
		ST_FIN
	} ctl_state_t;

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_DBL,
		MM_ADD
	} mm_state_t;

	// Handshake between the sequencer and a multi-cycle unit.
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

endpackage

// ===== rtl/mrr_split.sv =====
module mrr_split #(
	parameter int WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mrr_pkg::unit_req_t           req,
	input  logic [WIDTH-1:0]             value,
	output mrr_pkg::unit_rsp_t           rsp,
	output logic [WIDTH-1:0]             odd,
	output logic [$clog2(WIDTH)-1:0]     twos
);

	localparam int KW = $clog2(WIDTH);

	logic             busy_q;
	logic [WIDTH-1:0] m_q;
	logic [KW-1:0]    k_q;
	logic             finish;

	// The value is nonzero, so a set low bit is always reached.
	assign finish   = busy_q && m_q[0];
	assign rsp.done = finish;
	assign odd      = m_q;
	assign twos     = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			m_q <= value;
			k_q <= '0;
		end else if (busy_q && !m_q[0]) begin
			m_q <= {1'b0, m_q[WIDTH-1:1]};
			k_q <= k_q + KW'(1);
		end
	end

endmodule

// ===== rtl/mrr_modmul.sv =====
module mrr_modmul #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mrr_pkg::unit_req_t req,
	input  logic [WIDTH-1:0]   x,
	input  logic [WIDTH-1:0]   y,
	input  logic [WIDTH-1:0]   n,
	output mrr_pkg::unit_rsp_t rsp,
	output logic [WIDTH-1:0]   p
);

	localparam int CW = $clog2(WIDTH + 1);

	mrr_pkg::mm_state_t state_q, state_d;

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] y_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;

	logic             use_x;
	logic             step;
	logic             shift;
	logic             last;
	logic [WIDTH-1:0] addend;
	logic [WIDTH:0]   sum;
	logic [WIDTH+1:0] diff;
	logic [WIDTH-1:0] red;

	// Both operands are below n, so one conditional subtract reduces the sum.
	assign addend = use_x ? x : acc_q;
	assign sum    = {1'b0, acc_q} + {1'b0, addend};
	assign diff   = {1'b0, sum} - {2'b00, n};
	assign red    = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrr_pkg::MM_IDLE: begin
				if (req.start) begin
					state_d = mrr_pkg::MM_DBL;
				end
			end
			mrr_pkg::MM_DBL: begin
				if (y_q[WIDTH-1]) begin
					state_d = mrr_pkg::MM_ADD;
				end else if (cnt_q == CW'(1)) begin
					state_d = mrr_pkg::MM_IDLE;
				end
			end
			mrr_pkg::MM_ADD: begin
				if (cnt_q == CW'(1)) begin
					state_d = mrr_pkg::MM_IDLE;
				end else begin
					state_d = mrr_pkg::MM_DBL;
				end
			end
			default: state_d = mrr_pkg::MM_IDLE;
		endcase
	end

	always_comb begin
		use_x = 1'b0;
		step  = 1'b0;
		shift = 1'b0;
		unique case (state_q)
			mrr_pkg::MM_IDLE: begin
			end
			mrr_pkg::MM_DBL: begin
				step  = 1'b1;
				shift = !y_q[WIDTH-1];
			end
			mrr_pkg::MM_ADD: begin
				use_x = 1'b1;
				step  = 1'b1;
				shift = 1'b1;
			end
			default: begin
			end
		endcase
		last = shift && (cnt_q == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrr_pkg::MM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mrr_pkg::MM_IDLE && req.start) begin
			acc_q <= '0;
			y_q   <= y;
			cnt_q <= CW'(WIDTH);
		end else begin
			if (step) begin
				acc_q <= red;
			end
			if (shift) begin
				y_q   <= {y_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign rsp.done = done_q;
	assign p        = acc_q;

endmodule

// ===== rtl/miller_rabin_round.sv =====
// Channel  Direction  Handshake          Beat contents
// input    in         in_valid/in_stall   candidate, witness
// output   out        out_valid/out_stall verdict, odd_part, twos_count
//
// A multiplication holds the sequencer through a start, one doubling per multiplier bit
// plus one add per one bit, and a done strobe. The odd part has at most WIDTH-k bits, so
// the power and the k check squarings need at most 2*WIDTH multiplications, and an
// invalid item skips the split and the power and goes straight to the finish state.
// Reset clears the sequencer and the output valid; the block takes one item
// at a time and holds a finished beat in the output register while stalled.
module miller_rabin_round #(
	parameter int WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mrr_pkg::FIELD_W-1:0]       candidate,
	input  logic [mrr_pkg::FIELD_W-1:0]       witness,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mrr_pkg::VERDICT_W-1:0]     verdict,
	output logic [mrr_pkg::FIELD_W-1:0]       odd_part,
	output logic [mrr_pkg::COUNT_W-1:0]       twos_count
);

	localparam int KW = $clog2(WIDTH);
	localparam int CW = $clog2(WIDTH + 1);

	mrr_pkg::ctl_state_t state_q, state_d;

	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] nm1_q;
	logic [WIDTH-1:0] z_q;
	logic [WIDTH-1:0] e_q;
	logic [CW-1:0]    cnt_q;
	logic [KW-1:0]    i_q;
	logic             inv_q;
	logic [mrr_pkg::VERDICT_W-1:0] verd_q;

	logic                          out_valid_q;
	logic [mrr_pkg::VERDICT_W-1:0] verdict_q;
	logic [mrr_pkg::FIELD_W-1:0]   odd_part_q;
	logic [mrr_pkg::COUNT_W-1:0]   twos_count_q;

	logic               accept;
	logic               invalid;
	logic               out_free;
	mrr_pkg::unit_req_t split_req;
	mrr_pkg::unit_rsp_t split_rsp;
	mrr_pkg::unit_req_t mul_req;
	mrr_pkg::unit_rsp_t mul_rsp;
	logic [WIDTH-1:0]   split_m;
	logic [KW-1:0]      split_k;
	logic [WIDTH-1:0]   mul_x;
	logic [WIDTH-1:0]   mul_p;

	assign in_stall = (state_q != mrr_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The witness must lie in 1..n-2, which is a+1 < n once n is at least 3.
	assign invalid = (n_q < WIDTH'(3)) || (a_q == '0) ||
		(({1'b0, a_q} + (WIDTH + 1)'(1)) >= {1'b0, n_q});

	mrr_split #(
		.WIDTH(WIDTH)
	) u_split (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (split_req),
		.value (nm1_q),
		.rsp   (split_rsp),
		.odd   (split_m),
		.twos  (split_k)
	);

	// The multiplier reads x on every add, so the witness stays selected until it finishes.
	assign mul_x = (state_q == mrr_pkg::ST_MUL_GO || state_q == mrr_pkg::ST_MUL_WAIT) ?
		a_q : z_q;

	mrr_modmul #(
		.WIDTH(WIDTH)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req),
		.x     (mul_x),
		.y     (z_q),
		.n     (n_q),
		.rsp   (mul_rsp),
		.p     (mul_p)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = mrr_pkg::ST_CHECK;
				end
			end
			mrr_pkg::ST_CHECK: begin
				state_d = invalid ? mrr_pkg::ST_FIN : mrr_pkg::ST_SPLIT;
			end
			mrr_pkg::ST_SPLIT: begin
				if (split_rsp.done) begin
					state_d = mrr_pkg::ST_SKIP;
				end
			end
			mrr_pkg::ST_SKIP: begin
				if (e_q[WIDTH-1]) begin
					state_d = mrr_pkg::ST_SQR_GO;
				end
			end
			mrr_pkg::ST_SQR_GO:   state_d = mrr_pkg::ST_SQR_WAIT;
			mrr_pkg::ST_SQR_WAIT: begin
				if (mul_rsp.done) begin
					state_d = e_q[WIDTH-1] ? mrr_pkg::ST_MUL_GO : mrr_pkg::ST_STEP;
				end
			end
			mrr_pkg::ST_MUL_GO:   state_d = mrr_pkg::ST_MUL_WAIT;
			mrr_pkg::ST_MUL_WAIT: begin
				if (mul_rsp.done) begin
					state_d = mrr_pkg::ST_STEP;
				end
			end
			mrr_pkg::ST_STEP: begin
				state_d = (cnt_q == CW'(1)) ? mrr_pkg::ST_EVAL : mrr_pkg::ST_SQR_GO;
			end
			mrr_pkg::ST_EVAL: begin
				state_d = (z_q == WIDTH'(1)) ? mrr_pkg::ST_FIN : mrr_pkg::ST_TEST;
			end
			mrr_pkg::ST_TEST: begin
				if (i_q == split_k || z_q == nm1_q) begin
					state_d = mrr_pkg::ST_FIN;
				end else begin
					state_d = mrr_pkg::ST_SQB_GO;
				end
			end
			mrr_pkg::ST_SQB_GO:   state_d = mrr_pkg::ST_SQB_WAIT;
			mrr_pkg::ST_SQB_WAIT: begin
				if (mul_rsp.done) begin
					state_d = mrr_pkg::ST_TEST;
				end
			end
			mrr_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = mrr_pkg::ST_IDLE;
				end
			end
			default: state_d = mrr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		split_req.start = 1'b0;
		mul_req.start   = 1'b0;
		unique case (state_q)
			mrr_pkg::ST_CHECK: split_req.start = !invalid;
			mrr_pkg::ST_SQR_GO,
			mrr_pkg::ST_MUL_GO,
			mrr_pkg::ST_SQB_GO: mul_req.start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mrr_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mrr_pkg::ST_IDLE: begin
				if (accept) begin
					n_q   <= WIDTH'(candidate);
					a_q   <= WIDTH'(witness);
					nm1_q <= WIDTH'(candidate) - WIDTH'(1);
				end
			end
			mrr_pkg::ST_CHECK: begin
				inv_q  <= invalid;
				verd_q <= mrr_pkg::VERDICT_INVALID;
			end
			mrr_pkg::ST_SPLIT: begin
				if (split_rsp.done) begin
					e_q   <= split_m;
					cnt_q <= CW'(WIDTH);
					z_q   <= WIDTH'(1);
				end
			end
			mrr_pkg::ST_SKIP: begin
				if (!e_q[WIDTH-1]) begin
					e_q   <= {e_q[WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
				end
			end
			mrr_pkg::ST_SQR_WAIT,
			mrr_pkg::ST_MUL_WAIT,
			mrr_pkg::ST_SQB_WAIT: begin
				if (mul_rsp.done) begin
					z_q <= mul_p;
				end
			end
			mrr_pkg::ST_STEP: begin
				e_q   <= {e_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			mrr_pkg::ST_EVAL: begin
				i_q    <= '0;
				verd_q <= (z_q == WIDTH'(1)) ? mrr_pkg::VERDICT_PRIME
					: mrr_pkg::VERDICT_COMPOSITE;
			end
			mrr_pkg::ST_TEST: begin
				if (z_q == nm1_q && i_q != split_k) begin
					verd_q <= mrr_pkg::VERDICT_PRIME;
				end
				i_q <= i_q + KW'(1);
			end
			mrr_pkg::ST_FIN: begin
				if (out_free) begin
					verdict_q    <= verd_q;
					odd_part_q   <= inv_q ? '0 : mrr_pkg::FIELD_W'(split_m);
					twos_count_q <= inv_q ? '0 : mrr_pkg::COUNT_W'(split_k);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign odd_part   = odd_part_q;
	assign twos_count = twos_count_q;

	// A new beat appears on the output only when the sequencer finishes an item.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == mrr_pkg::ST_FIN))
		else $error("output beat raised outside the finish state");

	// A valid verdict always carries an odd factor of n-1.
	a_odd_part: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict != mrr_pkg::VERDICT_INVALID) |-> odd_part[0])
		else $error("odd_part is even on a valid verdict");

	// An invalid verdict carries zero in both factor fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == mrr_pkg::VERDICT_INVALID) |->
		(odd_part == '0 && twos_count == '0))
		else $error("invalid verdict with nonzero fields");

	// The multiplier reports completion only while the sequencer waits for it.
	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == mrr_pkg::ST_SQR_WAIT ||
		state_q == mrr_pkg::ST_MUL_WAIT || state_q == mrr_pkg::ST_SQB_WAIT))
		else $error("multiplier finished outside a wait state");

endmodule

// ===== bench/miller_rabin_round_test.sv =====
module miller_rabin_round_test;

	localparam int HOLD_CYCLES = 15000;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [mrr_pkg::VERDICT_W-1:0] verdict;
		logic [mrr_pkg::FIELD_W-1:0]   odd_part;
		logic [mrr_pkg::COUNT_W-1:0]   twos_count;
	} round_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [mrr_pkg::FIELD_W-1:0]   candidate = '0;
	logic [mrr_pkg::FIELD_W-1:0]   witness = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [mrr_pkg::VERDICT_W-1:0] verdict;
	logic [mrr_pkg::FIELD_W-1:0]   odd_part;
	logic [mrr_pkg::COUNT_W-1:0]   twos_count;

	logic          idle_on = 1'b1;
	logic          hold_on = 1'b0;
	int            stall_left = 0;
	int            cycles = 0;
	int            errors = 0;
	int            rounds_sent = 0;
	int            seen_composite = 0;
	int            seen_prime = 0;
	int            seen_invalid = 0;
	round_result_t pending_verdicts[$];
	round_result_t want;

	miller_rabin_round uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.candidate(candidate),
		.witness(witness),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict),
		.odd_part(odd_part),
		.twos_count(twos_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Operands are below 2^32, so a 64-bit product reduced with % is exact.
	function automatic logic [63:0] power_mod(logic [63:0] base, logic [31:0] e,
			logic [63:0] n);
		logic [63:0] z;
		z = 64'd1 % n;
		for (int i = 31; i >= 0; i--) begin
			z = (z * z) % n;
			if (e[i])
				z = (z * base) % n;
		end
		return z;
	endfunction

	function automatic round_result_t predict_round(logic [31:0] n, logic [31:0] a);
		round_result_t r;
		logic [63:0]   m;
		logic [63:0]   b;
		int            k;
		r = '0;
		if (n < 32'd3 || a < 32'd1 || a > n - 32'd2) begin
			r.verdict = mrr_pkg::VERDICT_INVALID;
			return r;
		end
		m = {32'd0, n - 32'd1};
		k = 0;
		while (!m[0]) begin
			m = m >> 1;
			k++;
		end
		b = power_mod({32'd0, a}, m[31:0], {32'd0, n});
		r.verdict = (b == 64'd1) ? mrr_pkg::VERDICT_PRIME : mrr_pkg::VERDICT_COMPOSITE;
		if (b != 64'd1) begin
			for (int i = 0; i < k; i++) begin
				if (b == {32'd0, n - 32'd1}) begin
					r.verdict = mrr_pkg::VERDICT_PRIME;
					break;
				end
				b = (b * b) % {32'd0, n};
			end
		end
		r.odd_part = m[31:0];
		r.twos_count = k[mrr_pkg::COUNT_W-1:0];
		return r;
	endfunction

	// Output side: short random stall bursts, plus the long hold when requested.
	always @(posedge clk or negedge arst_n) begin
		int left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			left = stall_left;
			if (left != 0)
				left--;
			else if (idle_on && $urandom_range(9) == 0)
				left = $urandom_range(4, 1);
			stall_left <= left;
			out_stall <= hold_on || (left != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected beat: verdict %0d odd_part %h twos_count %0d",
					$time, verdict, odd_part, twos_count);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (verdict !== want.verdict) begin
					$display("%0t: verdict expected %0d actual %0d",
						$time, want.verdict, verdict);
					errors++;
				end
				if (odd_part !== want.odd_part) begin
					$display("%0t: odd_part expected %h actual %h",
						$time, want.odd_part, odd_part);
					errors++;
				end
				if (twos_count !== want.twos_count) begin
					$display("%0t: twos_count expected %0d actual %0d",
						$time, want.twos_count, twos_count);
					errors++;
				end
				case (want.verdict)
					mrr_pkg::VERDICT_COMPOSITE: seen_composite++;
					mrr_pkg::VERDICT_PRIME:     seen_prime++;
					default:                    seen_invalid++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding",
				$time, pending_verdicts.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_round(input logic [31:0] n, input logic [31:0] a);
		round_result_t r;
		r = predict_round(n, a);
		if (idle_on && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		candidate <= n;
		witness <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rounds_sent++;
		pending_verdicts.push_back(r);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] known_prime(int idx);
		case (idx)
			0:       return 32'd3;
			1:       return 32'd5;
			2:       return 32'd13;
			3:       return 32'd97;
			4:       return 32'd65537;
			5:       return 32'd998244353;
			6:       return 32'd2147483647;
			default: return 32'd4294967291;
		endcase
	endfunction

	// Composites that pass for some bases: strong pseudoprimes and Carmichael numbers.
	function automatic logic [31:0] tricky_composite(int idx);
		case (idx)
			0:       return 32'd561;
			1:       return 32'd2047;
			2:       return 32'd41041;
			3:       return 32'd1373653;
			4:       return 32'd25326001;
			default: return 32'd3215031751;
		endcase
	endfunction

	function automatic logic [31:0] pick_witness(logic [31:0] n);
		case ($urandom_range(7))
			0:       return 32'd1;
			1:       return n - 32'd2;
			2:       return n - 32'd1 - $urandom_range(n - 32'd3 < 32'd5 ? n - 32'd3 : 5, 1);
			default: return $urandom_range(n - 32'd2, 1);
		endcase
	endfunction

	task automatic random_round();
		logic [31:0] n;
		logic [31:0] a;
		int          sel;
		int          k;
		sel = $urandom_range(99);
		if (sel < 15) begin
			n = ($urandom_range(3) == 0) ? $urandom_range(2, 0) : $urandom;
			a = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
		end else begin
			if (sel < 35)
				n = known_prime($urandom_range(7));
			else if (sel < 50)
				n = tricky_composite($urandom_range(5));
			else if (sel < 60) begin
				n = $urandom & 32'hFFFF_FFFE;
				if (n < 32'd4)
					n = 32'd4;
			end else begin
				// n - 1 = 2^k * m with a chosen k, so twos_count spans its range.
				k = $urandom_range(31, 1);
				n = ((($urandom >> k) | 32'd1) << k) + 32'd1;
			end
			a = pick_witness(n);
		end
		send_round(n, a);
	endtask

	task automatic test_invalid_inputs();
		send_round(32'd0, 32'd0);
		send_round(32'd1, 32'd1);
		send_round(32'd2, 32'd1);
		send_round(32'd3, 32'd0);
		send_round(32'd3, 32'd2);
		send_round(32'd101, 32'd100);
		send_round(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_round(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_round(32'd5, 32'hFFFF_FFFF);
		wait_for_results();
	endtask

	task automatic test_known_numbers();
		send_round(32'd3, 32'd1);
		send_round(32'hFFFF_FFFF, 32'hFFFF_FFFD);
		send_round(32'd4294967291, 32'd4294967289);
		send_round(32'h8000_0001, 32'd3);
		send_round(32'd2047, 32'd2);
		send_round(32'd561, 32'd2);
		send_round(32'd13, 32'd5);
		send_round(32'd998244353, 32'd3);
		send_round(32'd65537, 32'h1234);
		wait_for_results();
	endtask

	// With n even, n - 1 is odd and only b == 1 can give a prime verdict.
	task automatic test_even_candidates();
		send_round(32'd4, 32'd1);
		send_round(32'd4, 32'd2);
		send_round(32'hFFFF_FFFE, 32'h7FFF_FFFF);
		wait_for_results();
	endtask

	task automatic test_output_hold();
		hold_on <= 1'b1;
		fork
			begin
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		send_round(32'd97, 32'd5);
		send_round(32'd2147483647, 32'd48271);
		send_round(32'd1, 32'd0);
		send_round(32'd7, 32'd6);
		send_round(32'd0, 32'hFFFF_FFFF);
		send_round(32'd9, 32'd0);
		wait_for_results();
	endtask

	task automatic test_random_rounds(input int count);
		repeat (count)
			random_round();
		wait_for_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_invalid_inputs();
		test_known_numbers();
		test_even_candidates();
		test_output_hold();
		test_random_rounds(85);
		// The last stretch runs back to back with no stalls or gaps.
		idle_on <= 1'b0;
		@(posedge clk);
		test_random_rounds(30);
		repeat (20) @(posedge clk);
		$display("%0d rounds sent in %0d cycles, including a long output hold.",
			rounds_sent, cycles);
		$display("Verdicts checked: %0d composite, %0d probably prime, %0d invalid.",
			seen_composite, seen_prime, seen_invalid);
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mrr_pkg.sv
rtl/mrr_split.sv
rtl/mrr_modmul.sv
rtl/miller_rabin_round.sv
bench/miller_rabin_round_test.sv
